@@ sv/tem_pkg.sv @@
`default_nettype none
package tem_pkg;

  // Width of one event counter, the time stamp and the quotient.
  localparam int unsigned WORD_W = 64;
  // Number of raw event counters per task.
  localparam int unsigned CNT_N = 6;

  // Input function codes.
  localparam logic [1:0] FUNC_SLICE_END = 2'd0;
  localparam logic [1:0] FUNC_QUERY     = 2'd1;
  localparam logic [1:0] FUNC_TASK_RST  = 2'd2;
  localparam logic [1:0] FUNC_LATCH     = 2'd3;

  // Configuration register indexes.
  localparam logic REG_CORE_TYPE = 1'b0;

  typedef logic [CNT_N-1:0][WORD_W-1:0] cnt_arr_t;

  // One task record as it lies in the task memory.
  typedef struct packed {
    logic                  kind;
    logic [WORD_W-1:0]     start;
    cnt_arr_t              counts;
  } row_t;

  // Regression coefficient for a core kind and counter, two's complement.
  function automatic logic [WORD_W-1:0] coef_f(logic kind, logic [2:0] idx);
    logic [WORD_W-1:0] c;
    case ({kind, idx})
      4'b0_000: c = 64'(305);
      4'b0_001: c = 64'(47);
      4'b0_010: c = 64'(-1622);
      4'b0_011: c = 64'(-189);
      4'b0_100: c = 64'(5001);
      4'b0_101: c = 64'(267);
      4'b1_000: c = 64'(789);
      4'b1_001: c = 64'(332);
      4'b1_010: c = 64'(1165);
      4'b1_011: c = 64'(31);
      4'b1_100: c = 64'(666);
      4'b1_101: c = 64'(109);
      default:  c = '0;
    endcase
    return c;
  endfunction

  // True where the counter enters the model as a squared term.
  function automatic logic sq_f(logic kind, logic [2:0] idx);
    logic s;
    case ({kind, idx})
      4'b0_010: s = 1'b1;
      default:  s = 1'b0;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

@@ sv/tem_ram.sv @@
`default_nettype none
module tem_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire tem_pkg::row_t wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output tem_pkg::row_t      rdata_o
);

  tem_pkg::row_t mem [DEPTH];
  tem_pkg::row_t rdata_q;

  // Synchronous write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

@@ sv/tem_mul.sv @@
`default_nettype none
module tem_mul (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [63:0]  a_i,
  input  wire logic [63:0]  b_i,
  output logic              done_o,
  output logic [127:0]      p_o
);

  logic [63:0]  a_q, b_q;
  logic [127:0] acc_q, acc_d;
  logic [63:0]  pp_q, pp_d;
  logic [2:0]   step_q, step_d;
  logic         busy_q, busy_d;
  logic         done_q, done_d;
  logic [31:0]  a_half, b_half;
  logic [127:0] term;

  // Four 32x32 partial products, one per cycle, each summed in the cycle after.
  always_comb begin
    a_half = step_q[1] ? a_q[63:32] : a_q[31:0];
    b_half = step_q[0] ? b_q[63:32] : b_q[31:0];
    pp_d   = a_half * b_half;
    case (step_q)
      3'd1:    term = {64'd0, pp_q};
      3'd2:    term = {32'd0, pp_q, 32'd0};
      3'd3:    term = {32'd0, pp_q, 32'd0};
      3'd4:    term = {pp_q, 64'd0};
      default: term = '0;
    endcase
  end

  // Step sequence; the last two steps apply the signed corrections.
  always_comb begin
    acc_d  = acc_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      acc_d  = '0;
      step_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      step_d = step_q + 3'd1;
      case (step_q)
        3'd5: begin
          acc_d[127:64] = acc_q[127:64] - (a_q[63] ? b_q : 64'd0);
        end
        3'd6: begin
          acc_d[127:64] = acc_q[127:64] - (b_q[63] ? a_q : 64'd0);
          busy_d        = 1'b0;
          done_d        = 1'b1;
        end
        default: begin
          acc_d = acc_q + term;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      step_q <= step_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      b_q <= b_i;
    end
    acc_q <= acc_d;
    pp_q  <= pp_d;
  end

  assign done_o = done_q;
  assign p_o    = acc_q;

endmodule
`default_nettype wire

@@ sv/tem_div.sv @@
`default_nettype none
module tem_div (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [127:0] num_i,
  input  wire logic [63:0]  den_i,
  output logic              done_o,
  output logic [63:0]       q_o
);

  localparam logic [1:0] D_IDLE = 2'd0;
  localparam logic [1:0] D_RUN  = 2'd1;
  localparam logic [1:0] D_FIN  = 2'd2;

  localparam logic [63:0] POS_MAX = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] NEG_MIN = 64'h8000_0000_0000_0000;

  logic [1:0]   state_q, state_d;
  logic [6:0]   cnt_q, cnt_d;
  logic         done_q, done_d;
  logic         neg_q;
  logic [127:0] n_q;
  logic [63:0]  r_q, d_q, q_q;
  logic [64:0]  r2;
  logic         ge;
  logic [63:0]  qh, ql, q_fin;

  // One restoring step: shift in one numerator bit, subtract if it fits.
  always_comb begin
    r2 = {r_q, n_q[127]};
    ge = r2 >= {1'b0, d_q};
    qh = n_q[127:64];
    ql = n_q[63:0];
    if (!neg_q) begin
      q_fin = (qh != 64'd0 || ql[63]) ? POS_MAX : ql;
    end else begin
      q_fin = (qh != 64'd0 || ql > NEG_MIN) ? NEG_MIN : (~ql + 64'd1);
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    case (state_q)
      D_IDLE: begin
        if (start_i) begin
          state_d = D_RUN;
          cnt_d   = '0;
        end
      end
      D_RUN: begin
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'd127) begin
          state_d = D_FIN;
        end
      end
      D_FIN: begin
        state_d = D_IDLE;
        done_d  = 1'b1;
      end
      default: state_d = D_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  // The numerator register collects the quotient bits as it shifts out.
  always_ff @(posedge clk_i) begin
    if (state_q == D_IDLE && start_i) begin
      neg_q <= num_i[127];
      n_q   <= num_i[127] ? (~num_i + 128'd1) : num_i;
      r_q   <= '0;
      d_q   <= den_i;
    end else if (state_q == D_RUN) begin
      r_q <= ge ? 64'(r2 - {1'b0, d_q}) : r2[63:0];
      n_q <= {n_q[126:0], ge};
    end
    if (state_q == D_FIN) begin
      q_q <= q_fin;
    end
  end

  assign done_o = done_q;
  assign q_o    = q_q;

endmodule
`default_nettype wire

@@ sv/tem_est.sv @@
`default_nettype none
module tem_est (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic              kind_i,
  input  wire tem_pkg::cnt_arr_t counts_i,
  input  wire logic [63:0]       dur_i,
  output logic                   done_o,
  output logic [62:0]            power_o
);

  localparam logic [2:0] E_IDLE = 3'd0;
  localparam logic [2:0] E_SQ   = 3'd1;
  localparam logic [2:0] E_SQW1 = 3'd2;
  localparam logic [2:0] E_SQW2 = 3'd3;
  localparam logic [2:0] E_D1   = 3'd4;
  localparam logic [2:0] E_D1W  = 3'd5;
  localparam logic [2:0] E_LIN  = 3'd6;
  localparam logic [2:0] E_LW   = 3'd7;

  localparam logic [2:0] LAST_IDX = 3'(tem_pkg::CNT_N);

  logic [2:0]        state_q, state_d;
  logic [2:0]        idx_q, idx_d;
  logic              done_q, done_d;
  logic              fin_q, fin_d;
  logic [127:0]      acc_q, acc_d;
  logic [62:0]       power_q, power_d;
  logic              kind_q;
  tem_pkg::cnt_arr_t cnt_q;
  logic [63:0]       dur_q;
  logic [63:0]       m;

  logic         mul_start, mul_done;
  logic [63:0]  mul_a, mul_b;
  logic [127:0] mul_p;
  logic         div_start, div_done;
  logic [63:0]  div_q;

  tem_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  tem_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (acc_q),
    .den_i   (dur_q),
    .done_o  (div_done),
    .q_o     (div_q)
  );

  assign m = (idx_q < LAST_IDX) ? cnt_q[idx_q] : 64'd0;

  // Squared terms, a division unless their sum is zero, then linear terms and the final division.
  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    acc_d     = acc_q;
    power_d   = power_q;
    fin_d     = fin_q;
    done_d    = 1'b0;
    mul_start = 1'b0;
    mul_a     = tem_pkg::coef_f(kind_q, idx_q);
    mul_b     = m;
    div_start = 1'b0;
    case (state_q)
      E_IDLE: begin
        if (start_i) begin
          state_d = E_SQ;
          idx_d   = '0;
          acc_d   = '0;
          fin_d   = 1'b0;
        end
      end
      E_SQ: begin
        if (idx_q == LAST_IDX) begin
          state_d = E_D1;
        end else if (tem_pkg::sq_f(kind_q, idx_q)) begin
          mul_start = 1'b1;
          state_d   = E_SQW1;
        end else begin
          idx_d = idx_q + 3'd1;
        end
      end
      E_SQW1: begin
        // The coefficient product wraps to 64 bits before it meets m again.
        mul_a = mul_p[63:0];
        if (mul_done) begin
          mul_start = 1'b1;
          state_d   = E_SQW2;
        end
      end
      E_SQW2: begin
        if (mul_done) begin
          acc_d   = acc_q + mul_p;
          idx_d   = idx_q + 3'd1;
          state_d = E_SQ;
        end
      end
      E_D1: begin
        if (acc_q != 128'd0) begin
          div_start = 1'b1;
          state_d   = E_D1W;
        end else begin
          idx_d   = '0;
          state_d = E_LIN;
        end
      end
      E_D1W: begin
        if (div_done) begin
          if (fin_q) begin
            power_d = div_q[63] ? 63'd0 : div_q[62:0];
            done_d  = 1'b1;
            state_d = E_IDLE;
          end else begin
            acc_d   = {{64{div_q[63]}}, div_q};
            idx_d   = '0;
            state_d = E_LIN;
          end
        end
      end
      E_LIN: begin
        if (idx_q == LAST_IDX) begin
          div_start = 1'b1;
          fin_d     = 1'b1;
          state_d   = E_D1W;
        end else if (!tem_pkg::sq_f(kind_q, idx_q)) begin
          mul_start = 1'b1;
          state_d   = E_LW;
        end else begin
          idx_d = idx_q + 3'd1;
        end
      end
      E_LW: begin
        if (mul_done) begin
          acc_d   = acc_q + mul_p;
          idx_d   = idx_q + 3'd1;
          state_d = E_LIN;
        end
      end
      default: state_d = E_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= E_IDLE;
      idx_q   <= '0;
      done_q  <= 1'b0;
      fin_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      done_q  <= done_d;
      fin_q   <= fin_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == E_IDLE && start_i) begin
      kind_q <= kind_i;
      cnt_q  <= counts_i;
      dur_q  <= dur_i;
    end
    acc_q   <= acc_d;
    power_q <= power_d;
  end

  assign done_o  = done_q;
  assign power_o = power_q;

endmodule
`default_nettype wire

@@ sv/task_energy_model_estimator_core.sv @@
// Channel   Direction  Handshake                   Word
// in        input      in_valid_i / in_ready_o     func, task ids, time, six raw counters
// out       output     out_valid_o / out_ready_i   avg_mw
// cfg       input      APB psel/penable/pwrite     cpu_core_type at address 0
//
// After reset the task memory is cleared, one task row a cycle, through all TASK_SLOTS
// rows; no word is accepted during that pass.
// Latch baseline only updates the baseline, task reset rewrites the row, and a
// timeslice end makes up to two read-modify-write passes on the task memory, which
// has one write port and one read port. A query runs the serial 128-by-64 divider
// (one quotient bit a cycle, up to two runs) and the 32x32 partial-product multiplier.
// A finished result waits in the output register; the next word is accepted
// meanwhile, and a later query holds in its last step until that register is free.
`default_nettype none
module task_energy_model_estimator_core #(
  parameter int unsigned TASK_SLOTS = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  func_i,
  input  wire logic [5:0]  task_id_i,
  input  wire logic [5:0]  next_task_id_i,
  input  wire logic [63:0] now_ns_i,
  input  wire logic [63:0] raw_count_a_i,
  input  wire logic [63:0] raw_count_b_i,
  input  wire logic [63:0] raw_count_c_i,
  input  wire logic [63:0] raw_count_d_i,
  input  wire logic [63:0] raw_count_e_i,
  input  wire logic [63:0] raw_count_f_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [62:0]      avg_mw_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int unsigned AW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam logic [AW-1:0] LAST_ROW = AW'(TASK_SLOTS - 1);

  localparam logic [3:0] S_CLR    = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_TS_RD  = 4'd2;
  localparam logic [3:0] S_TS_WR  = 4'd3;
  localparam logic [3:0] S_NX_RD  = 4'd4;
  localparam logic [3:0] S_NX_WR  = 4'd5;
  localparam logic [3:0] S_Q_RD   = 4'd6;
  localparam logic [3:0] S_Q_GO   = 4'd7;
  localparam logic [3:0] S_Q_WAIT = 4'd8;
  localparam logic [3:0] S_OUT    = 4'd9;
  localparam logic [3:0] S_RST    = 4'd10;

  logic [3:0]        state_q, state_d;
  logic [AW-1:0]     clr_q, clr_d;
  logic              out_valid_q, out_valid_d;
  logic              core_type_q;
  tem_pkg::cnt_arr_t base_q;
  logic [1:0]        func_q;
  logic [5:0]        tid_q, nid_q;
  logic [63:0]       now_q;
  tem_pkg::cnt_arr_t delta_q;
  logic [62:0]       res_q, power_q;

  tem_pkg::cnt_arr_t raw;
  logic              accept, nid_ok, in_tid_ok, ovf;
  logic              we;
  logic [AW-1:0]     waddr, raddr;
  tem_pkg::row_t     wdata, rdata, clear_row;
  tem_pkg::cnt_arr_t sums;
  logic [63:0]       elapsed, dur;
  logic              est_start, est_done;
  logic [62:0]       est_power;

  tem_ram #(
    .DEPTH (TASK_SLOTS),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  tem_est u_est (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (est_start),
    .kind_i   (rdata.kind),
    .counts_i (rdata.counts),
    .dur_i    (dur),
    .done_o   (est_done),
    .power_o  (est_power)
  );

  // Raw counters as one array, counter a first.
  always_comb begin
    raw[0] = raw_count_a_i;
    raw[1] = raw_count_b_i;
    raw[2] = raw_count_c_i;
    raw[3] = raw_count_d_i;
    raw[4] = raw_count_e_i;
    raw[5] = raw_count_f_i;
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign in_tid_ok  = 32'(task_id_i) < TASK_SLOTS;
  assign nid_ok     = 32'(nid_q) < TASK_SLOTS;

  // Sums of the task that ran; any carry out restarts its record.
  always_comb begin
    ovf = 1'b0;
    for (int i = 0; i < tem_pkg::CNT_N; i++) begin
      logic [64:0] s;
      s = {1'b0, rdata.counts[i]} + {1'b0, delta_q[i]};
      if (s[64]) begin
        ovf = 1'b1;
      end
    end
    for (int i = 0; i < tem_pkg::CNT_N; i++) begin
      sums[i] = ovf ? delta_q[i] : (rdata.counts[i] + delta_q[i]);
    end
  end

  // Elapsed time of the queried task, never below one.
  assign elapsed = now_q - rdata.start;
  assign dur     = (elapsed == 64'd0) ? 64'd1 : elapsed;

  // Task memory port control.
  always_comb begin
    clear_row        = '0;
    clear_row.start  = now_q;
    raddr            = (state_q == S_NX_RD) ? AW'(nid_q) : AW'(tid_q);
    we               = 1'b0;
    waddr            = AW'(tid_q);
    wdata            = clear_row;
    case (state_q)
      S_CLR: begin
        we    = 1'b1;
        waddr = clr_q;
        wdata = '0;
      end
      S_TS_WR: begin
        we           = 1'b1;
        wdata.kind   = rdata.kind;
        wdata.start  = ovf ? now_q : rdata.start;
        wdata.counts = sums;
      end
      S_NX_WR: begin
        we         = (rdata.kind != core_type_q);
        waddr      = AW'(nid_q);
        wdata.kind = core_type_q;
      end
      S_RST: begin
        we = 1'b1;
      end
      default: ;
    endcase
  end

  // Command sequencer.
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    out_valid_d = out_valid_q;
    est_start   = 1'b0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_CLR: begin
        clr_d = clr_q + AW'(1);
        if (clr_q == LAST_ROW) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          case (func_i)
            tem_pkg::FUNC_SLICE_END: state_d = in_tid_ok ? S_TS_RD : S_NX_RD;
            tem_pkg::FUNC_QUERY:     state_d = in_tid_ok ? S_Q_RD : S_OUT;
            tem_pkg::FUNC_TASK_RST:  state_d = in_tid_ok ? S_RST : S_IDLE;
            default:                 state_d = S_IDLE;
          endcase
        end
      end
      S_TS_RD:  state_d = S_TS_WR;
      S_TS_WR:  state_d = S_NX_RD;
      S_NX_RD:  state_d = nid_ok ? S_NX_WR : S_IDLE;
      S_NX_WR:  state_d = S_IDLE;
      S_Q_RD:   state_d = S_Q_GO;
      S_Q_GO: begin
        est_start = 1'b1;
        state_d   = S_Q_WAIT;
      end
      S_Q_WAIT: begin
        if (est_done) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_RST:    state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      core_type_q <= 1'b0;
      base_q      <= '0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      if (psel && penable && pwrite && pready && paddr[2] == tem_pkg::REG_CORE_TYPE) begin
        core_type_q <= pwdata[0];
      end
      if (accept && (func_i == tem_pkg::FUNC_SLICE_END || func_i == tem_pkg::FUNC_LATCH)) begin
        base_q <= raw;
      end
    end
  end

  // Captured command word and result.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= func_i;
      tid_q  <= task_id_i;
      nid_q  <= next_task_id_i;
      now_q  <= now_ns_i;
      for (int i = 0; i < tem_pkg::CNT_N; i++) begin
        delta_q[i] <= raw[i] - base_q[i];
      end
      if (func_i == tem_pkg::FUNC_QUERY) begin
        res_q <= '0;
      end
    end
    if (state_q == S_Q_WAIT && est_done) begin
      res_q <= est_power;
    end
    if (state_q == S_OUT && (!out_valid_q || out_ready_i) && func_q == tem_pkg::FUNC_QUERY) begin
      power_q <= res_q;
    end
  end

  // Register read.
  assign prdata      = (paddr[2] == tem_pkg::REG_CORE_TYPE) ? {31'd0, core_type_q} : 32'd0;
  assign pready      = 1'b1;
  assign out_valid_o = out_valid_q;
  assign avg_mw_o    = power_q;

endmodule
`default_nettype wire

@@ sv/tem_checker.sv @@
`default_nettype none
module tem_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic [1:0]  func_i,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [62:0] avg_mw_o,
  input wire logic [31:0] prdata,
  input wire logic        pready
);

  // A waiting result holds until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(avg_mw_o))
    else $error("result word changed while stalled");

  // No result appears in the cycle right after a word is accepted.
  a_no_quick_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !$rose(out_valid_o))
    else $error("result appeared too early");

  // A query keeps the input side busy.
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && func_i == tem_pkg::FUNC_QUERY |=> !in_ready_o)
    else $error("input accepted during a query");

  // The register port never waits.
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

  // Only the core type bit reads back.
  a_prdata: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prdata[31:1] == 31'd0)
    else $error("unused register bits set");

endmodule

bind task_energy_model_estimator_core tem_checker u_tem_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .func_i      (func_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .avg_mw_o    (avg_mw_o),
  .prdata      (prdata),
  .pready      (pready)
);
`default_nettype wire
